### src/svtt_pkg.sv
package svtt_pkg;

  // longest command, in bytes, that is still tracked
  localparam int MAX_VECTOR_BYTES = 4096;
  localparam int MAX_VECTOR_BITS  = MAX_VECTOR_BYTES * 8;

  localparam logic [7:0] BOGUS_IR_TMS = 8'h17;
  localparam logic [7:0] BOGUS_DR_TMS = 8'h0b;
  localparam logic [15:0] BOGUS_IR_LEN = 16'd5;
  localparam logic [15:0] BOGUS_DR_LEN = 16'd4;
  localparam logic [3:0] FULL_BYTE_BITS = 4'd8;

  // TAP controller states, standard order
  localparam logic [3:0] TAP_TLR   = 4'd0;
  localparam logic [3:0] TAP_RTI   = 4'd1;
  localparam logic [3:0] TAP_SELDR = 4'd2;
  localparam logic [3:0] TAP_CAPDR = 4'd3;
  localparam logic [3:0] TAP_SHDR  = 4'd4;
  localparam logic [3:0] TAP_EX1DR = 4'd5;
  localparam logic [3:0] TAP_PAUDR = 4'd6;
  localparam logic [3:0] TAP_EX2DR = 4'd7;
  localparam logic [3:0] TAP_UPDDR = 4'd8;
  localparam logic [3:0] TAP_SELIR = 4'd9;
  localparam logic [3:0] TAP_CAPIR = 4'd10;
  localparam logic [3:0] TAP_SHIR  = 4'd11;
  localparam logic [3:0] TAP_EX1IR = 4'd12;
  localparam logic [3:0] TAP_PAUIR = 4'd13;
  localparam logic [3:0] TAP_EX2IR = 4'd14;
  localparam logic [3:0] TAP_UPDIR = 4'd15;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_WALK
  } seq_state_t;

  typedef struct packed {
    logic [7:0]  tms_bits;
    logic [3:0]  bit_count;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] shift_length;
  } cmd_t;

  typedef struct packed {
    logic [3:0] tap_state;
    logic       move_skipped;
    logic       reset_seen;
    logic       session_done;
  } res_t;

  typedef struct packed {
    logic       load;
    logic [7:0] tms;
    logic [3:0] count;
  } walk_ctl_t;

  typedef struct packed {
    logic       busy;
    logic [3:0] tap;
  } walk_sts_t;

  // one TMS edge of the TAP controller
  function automatic logic [3:0] tap_next(input logic [3:0] st, input logic tms);
    logic [3:0] nxt;
    unique case (st)
      TAP_TLR:   nxt = tms ? TAP_TLR   : TAP_RTI;
      TAP_RTI:   nxt = tms ? TAP_SELDR : TAP_RTI;
      TAP_SELDR: nxt = tms ? TAP_SELIR : TAP_CAPDR;
      TAP_CAPDR: nxt = tms ? TAP_EX1DR : TAP_SHDR;
      TAP_SHDR:  nxt = tms ? TAP_EX1DR : TAP_SHDR;
      TAP_EX1DR: nxt = tms ? TAP_UPDDR : TAP_PAUDR;
      TAP_PAUDR: nxt = tms ? TAP_EX2DR : TAP_PAUDR;
      TAP_EX2DR: nxt = tms ? TAP_UPDDR : TAP_SHDR;
      TAP_UPDDR: nxt = tms ? TAP_SELDR : TAP_RTI;
      TAP_SELIR: nxt = tms ? TAP_TLR   : TAP_CAPIR;
      TAP_CAPIR: nxt = tms ? TAP_EX1IR : TAP_SHIR;
      TAP_SHIR:  nxt = tms ? TAP_EX1IR : TAP_SHIR;
      TAP_EX1IR: nxt = tms ? TAP_UPDIR : TAP_PAUIR;
      TAP_PAUIR: nxt = tms ? TAP_EX2IR : TAP_PAUIR;
      TAP_EX2IR: nxt = tms ? TAP_UPDIR : TAP_SHIR;
      TAP_UPDIR: nxt = tms ? TAP_SELDR : TAP_RTI;
      default:   nxt = TAP_TLR;
    endcase
    return nxt;
  endfunction

endpackage

### src/shift_vector_tap_tracker.sv
// channel | dir | payload          | handshake
// cmd     | in  | svtt_pkg::cmd_t  | cmd_valid / cmd_stall
// res     | out | svtt_pkg::res_t  | res_valid / res_stall
//
// The bit-serial walker steps the TAP table one TMS bit per cycle over the n
// valid TMS bits of a beat (n = 0..8, clamped).
// A skipped or dropped command walks no bits.
// Synchronous reset puts the TAP in Test-Logic-Reset and clears all flags.
// cmd_stall is high while a beat is being walked; a result waiting under
// res_stall blocks only the end of the next walk, not its acceptance.
module shift_vector_tap_tracker (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  svtt_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output svtt_pkg::res_t res
);

  svtt_pkg::seq_state_t state, state_next;
  svtt_pkg::walk_ctl_t  wctl;
  svtt_pkg::walk_sts_t  wsts;

  logic reset_flag, reset_flag_next;
  logic skip_command, skip_command_next;
  logic drop_command, drop_command_next;
  logic last_q;
  logic cmd_take;
  logic res_free;
  logic finish;
  logic [3:0] cnt_clamped;

  svtt_walker u_walker (
    .clk (clk),
    .rst (rst),
    .ctl (wctl),
    .sts (wsts)
  );

  assign cmd_take    = cmd_valid && !cmd_stall;
  assign res_free    = !res_valid || !res_stall;
  assign finish      = (state == svtt_pkg::SEQ_WALK) && !wsts.busy && res_free;
  assign cnt_clamped = cmd.bit_count[3] ? svtt_pkg::FULL_BYTE_BITS : cmd.bit_count;

  // first-byte decisions, taken from the TAP state at command start
  always_comb begin
    reset_flag_next   = reset_flag;
    skip_command_next = skip_command;
    drop_command_next = drop_command;
    if (cmd_take && cmd.first_byte) begin
      drop_command_next = 32'(cmd.shift_length) > 32'(svtt_pkg::MAX_VECTOR_BITS);
      skip_command_next = 1'b0;
      if (!drop_command_next) begin
        reset_flag_next = (reset_flag || wsts.tap == svtt_pkg::TAP_TLR) &&
                          wsts.tap != svtt_pkg::TAP_CAPDR &&
                          wsts.tap != svtt_pkg::TAP_CAPIR;
        skip_command_next =
          (wsts.tap == svtt_pkg::TAP_EX1IR && cmd.shift_length == svtt_pkg::BOGUS_IR_LEN &&
           cmd.tms_bits == svtt_pkg::BOGUS_IR_TMS) ||
          (wsts.tap == svtt_pkg::TAP_EX1DR && cmd.shift_length == svtt_pkg::BOGUS_DR_LEN &&
           cmd.tms_bits == svtt_pkg::BOGUS_DR_TMS);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      svtt_pkg::SEQ_IDLE: if (cmd_take) state_next = svtt_pkg::SEQ_WALK;
      svtt_pkg::SEQ_WALK: if (finish) state_next = svtt_pkg::SEQ_IDLE;
      default:            state_next = svtt_pkg::SEQ_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_stall  = 1'b1;
    wctl.load  = 1'b0;
    wctl.tms   = cmd.tms_bits;
    wctl.count = 4'd0;
    unique case (state)
      svtt_pkg::SEQ_IDLE: begin
        cmd_stall = 1'b0;
        wctl.load = cmd_take;
        // skipped or dropped beats leave the TAP where it is
        wctl.count = (skip_command_next || drop_command_next) ? 4'd0 : cnt_clamped;
      end
      svtt_pkg::SEQ_WALK: begin
        cmd_stall = 1'b1;
      end
      default: begin
        cmd_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= svtt_pkg::SEQ_IDLE;
      reset_flag   <= 1'b0;
      skip_command <= 1'b0;
      drop_command <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      reset_flag   <= reset_flag_next;
      skip_command <= skip_command_next;
      drop_command <= drop_command_next;
      if (finish) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      last_q <= cmd.last_byte;
    end
    if (finish) begin
      res.tap_state    <= wsts.tap;
      res.move_skipped <= skip_command || drop_command;
      res.reset_seen   <= reset_flag;
      res.session_done <= last_q && !drop_command && reset_flag &&
                          wsts.tap == svtt_pkg::TAP_RTI;
    end
  end

  // a beat is taken only when the walker has nothing left to step
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> !wsts.busy)
    else $error("beat accepted while walker busy");

  // a skipped or dropped command never moves the TAP
  a_skip_hold: assert property (@(posedge clk) disable iff (rst)
    (state == svtt_pkg::SEQ_WALK && (skip_command || drop_command)) |=> $stable(wsts.tap))
    else $error("TAP moved on an ignored command");

  // session end only reported from Run-Test/Idle with the flag set
  a_done_rti: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.session_done) |-> (res.tap_state == svtt_pkg::TAP_RTI && res.reset_seen))
    else $error("session end outside Run-Test/Idle");

  // a finished walk never overwrites a result still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    finish |-> (!res_valid || !res_stall))
    else $error("result overwritten under stall");

endmodule

### src/svtt_walker.sv
// bit-serial TAP walker: one TMS bit per cycle out of a shift register
module svtt_walker (
  input  logic                clk,
  input  logic                rst,
  input  svtt_pkg::walk_ctl_t ctl,
  output svtt_pkg::walk_sts_t sts
);

  logic [3:0] tap;
  logic [7:0] tms_sr;
  logic [3:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap   <= svtt_pkg::TAP_TLR;
      count <= 4'd0;
    end else if (ctl.load) begin
      count <= ctl.count;
    end else if (count != 4'd0) begin
      tap   <= svtt_pkg::tap_next(tap, tms_sr[0]);
      count <= count - 4'd1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      tms_sr <= ctl.tms;
    end else if (count != 4'd0) begin
      tms_sr <= {1'b0, tms_sr[7:1]};
    end
  end

  assign sts.busy = (count != 4'd0);
  assign sts.tap  = tap;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 8;
  localparam int RANDOM_BEATS  = 800;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 24;

  // TAP next-state tables, one nibble per state (state 0 in the low nibble)
  localparam logic [63:0] NEXT_ON_ZERO = 64'h1BDD_BBA1_4664_4311;
  localparam logic [63:0] NEXT_ON_ONE  = 64'h2FEF_CC02_8785_5920;

  // directed row: the beat plus an optional hand-written result
  typedef struct packed {
    svtt_pkg::cmd_t beat;
    logic           fixed;
    svtt_pkg::res_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  svtt_pkg::cmd_t cmd_beat = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  svtt_pkg::res_t res_beat;

  // tracker state mirrored by the testbench
  logic [3:0] tap_track = svtt_pkg::TAP_TLR;
  logic       seen_flag = 1'b0;
  logic       skip_cmd  = 1'b0;
  logic       drop_cmd  = 1'b0;

  svtt_pkg::res_t tracked_outcomes [$];
  plan_row_t      plan [$];
  int             errors = 0;
  int             beats_sent = 0;
  int             cycles = 0;
  bit             no_idle = 1'b0;

  shift_vector_tap_tracker DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd_beat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res_beat)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR %s", $time, msg);
    errors++;
  endtask

  // Advance the mirrored tracker by one beat and return the result it gives.
  function automatic svtt_pkg::res_t track_beat(input svtt_pkg::cmd_t c);
    svtt_pkg::res_t r;
    int unsigned    n;
    int unsigned    i;
    n = 32'((c.bit_count > svtt_pkg::FULL_BYTE_BITS) ? svtt_pkg::FULL_BYTE_BITS
                                                     : c.bit_count);
    if (c.first_byte) begin
      // decision is latched per command; later beats inherit it
      drop_cmd = ((int'(c.shift_length) + 7) / 8) > svtt_pkg::MAX_VECTOR_BYTES;
      skip_cmd = 1'b0;
      if (!drop_cmd) begin
        seen_flag = (seen_flag || tap_track == svtt_pkg::TAP_TLR) &&
                    tap_track != svtt_pkg::TAP_CAPDR && tap_track != svtt_pkg::TAP_CAPIR;
        skip_cmd = (tap_track == svtt_pkg::TAP_EX1IR &&
                    c.shift_length == svtt_pkg::BOGUS_IR_LEN &&
                    c.tms_bits == svtt_pkg::BOGUS_IR_TMS) ||
                   (tap_track == svtt_pkg::TAP_EX1DR &&
                    c.shift_length == svtt_pkg::BOGUS_DR_LEN &&
                    c.tms_bits == svtt_pkg::BOGUS_DR_TMS);
      end
    end
    if (!drop_cmd && !skip_cmd) begin
      for (i = 0; i < n; i++)
        tap_track = c.tms_bits[i] ? NEXT_ON_ONE[tap_track * 4 +: 4]
                                  : NEXT_ON_ZERO[tap_track * 4 +: 4];
    end
    r.tap_state    = tap_track;
    r.move_skipped = skip_cmd || drop_cmd;
    r.reset_seen   = seen_flag;
    r.session_done = c.last_byte && !drop_cmd && seen_flag &&
                     tap_track == svtt_pkg::TAP_RTI;
    return r;
  endfunction

  function automatic svtt_pkg::cmd_t beat_of(input logic [7:0] tms, input logic [3:0] cnt,
                                             input logic first, input logic last,
                                             input logic [15:0] len);
    svtt_pkg::cmd_t c;
    c.tms_bits     = tms;
    c.bit_count    = cnt;
    c.first_byte   = first;
    c.last_byte    = last;
    c.shift_length = len;
    return c;
  endfunction

  function automatic plan_row_t step_row(input logic [7:0] tms, input logic [3:0] cnt,
                                         input logic first, input logic last,
                                         input logic [15:0] len, input logic fixed,
                                         input svtt_pkg::res_t want);
    plan_row_t p;
    p.beat  = beat_of(tms, cnt, first, last, len);
    p.fixed = fixed;
    p.want  = want;
    return p;
  endfunction

  // Drive one beat after a random gap (none in full-rate stretches). Valid stays
  // high when the next beat follows with no gap, so it is never dropped and re-raised in one step.
  task automatic send_beat(input svtt_pkg::cmd_t c, input logic fixed,
                           input svtt_pkg::res_t want);
    int unsigned    gap;
    svtt_pkg::res_t got;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_beat  <= c;
    do @(posedge clk); while (cmd_stall);
    got = track_beat(c);
    tracked_outcomes.push_back(fixed ? want : got);
    beats_sent++;
    // alternate idle stretches with full-rate stretches
    no_idle = ((beats_sent / 64) % 4) == 3;
  endtask

  // sender holds off until every result is back
  task automatic drain_results();
    cmd_valid <= 1'b0;
    while (tracked_outcomes.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // One random command: mostly well-formed, with bogus moves steered in on some
  // draws while the tracker sits in an Exit1 state, plus oversized, reset and noise commands.
  task automatic random_command();
    int unsigned    kind;
    int unsigned    len;
    int unsigned    left;
    int unsigned    cnt;
    int unsigned    nbytes;
    int unsigned    k;
    int unsigned    r;
    logic [15:0]    len_field;
    svtt_pkg::cmd_t c;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      // raw noise: any count, any framing, any length
      c.tms_bits     = 8'($urandom);
      c.bit_count    = 4'($urandom);
      c.first_byte   = 1'($urandom);
      c.last_byte    = 1'($urandom);
      c.shift_length = 16'($urandom);
      send_beat(c, 1'b0, '0);
    end else if (kind < 16) begin
      // oversized command, only a few beats of it
      len    = $urandom_range(svtt_pkg::MAX_VECTOR_BITS + 1, 65535);
      nbytes = $urandom_range(1, 3);
      for (k = 0; k < nbytes; k++)
        send_beat(beat_of(8'($urandom), 4'($urandom_range(1, 8)), k == 0,
                          k == nbytes - 1, 16'(len)), 1'b0, '0);
    end else if (kind < 24) begin
      // five ones park the TAP in Test-Logic-Reset
      send_beat(beat_of({3'($urandom), 5'h1F}, 4'd5, 1'b1, 1'b1, 16'd5), 1'b0, '0);
    end else if (kind < 60 && (tap_track == svtt_pkg::TAP_EX1IR ||
                               tap_track == svtt_pkg::TAP_EX1DR)) begin
      nbytes = $urandom_range(1, 2);
      if (tap_track == svtt_pkg::TAP_EX1IR)
        c = beat_of(svtt_pkg::BOGUS_IR_TMS, 4'd5, 1'b1, nbytes == 1, svtt_pkg::BOGUS_IR_LEN);
      else
        c = beat_of(svtt_pkg::BOGUS_DR_TMS, 4'd4, 1'b1, nbytes == 1, svtt_pkg::BOGUS_DR_LEN);
      send_beat(c, 1'b0, '0);
      if (nbytes == 2)
        send_beat(beat_of(8'($urandom), 4'($urandom_range(1, 8)), 1'b0, 1'b1,
                          16'($urandom)), 1'b0, '0);
    end else begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
      r = $urandom_range(0, 29);
      len_field = 16'(len);
      if (r == 0)
        len_field = '0;
      else if (r == 1)
        len_field = 16'(svtt_pkg::MAX_VECTOR_BITS);
      left = len;
      k = 0;
      while (left > 0) begin
        cnt  = (left > 8) ? 8 : left;
        left = left - cnt;
        send_beat(beat_of(8'($urandom), 4'(cnt), k == 0, left == 0, len_field), 1'b0, '0);
        k++;
      end
    end
  endtask

  // Directed plan. Hand-written results only where obvious; the rest go
  // through the mirrored tracker.
  initial begin
    // out of reset: one zero reaches Run-Test/Idle, flag set -> session end
    plan.push_back(step_row(8'h00, 4'd1, 1'b1, 1'b1, 16'd5, 1'b1,
                            {svtt_pkg::TAP_RTI, 1'b0, 1'b1, 1'b1}));
    // walk to Exit1-IR
    plan.push_back(step_row(8'h0B, 4'd4, 1'b1, 1'b1, 16'd4, 1'b1,
                            {svtt_pkg::TAP_EX1IR, 1'b0, 1'b1, 1'b0}));
    // bogus IR move: state held
    plan.push_back(step_row(svtt_pkg::BOGUS_IR_TMS, 4'd5, 1'b1, 1'b1,
                            svtt_pkg::BOGUS_IR_LEN, 1'b1,
                            {svtt_pkg::TAP_EX1IR, 1'b1, 1'b1, 1'b0}));
    // beat with no opening first byte keeps the skip
    plan.push_back(step_row(8'hFF, 4'd8, 1'b0, 1'b1, 16'd0, 1'b1,
                            {svtt_pkg::TAP_EX1IR, 1'b1, 1'b1, 1'b0}));
    // upper bit differs from the bogus byte: not skipped; zero count moves nothing
    plan.push_back(step_row(8'h97, 4'd0, 1'b1, 1'b1, svtt_pkg::BOGUS_IR_LEN, 1'b1,
                            {svtt_pkg::TAP_EX1IR, 1'b0, 1'b1, 1'b0}));
    // Update-IR then Run-Test/Idle
    plan.push_back(step_row(8'h01, 4'd2, 1'b1, 1'b1, 16'd2, 1'b1,
                            {svtt_pkg::TAP_RTI, 1'b0, 1'b1, 1'b1}));
    // walk to Exit1-DR
    plan.push_back(step_row(8'h05, 4'd3, 1'b1, 1'b1, 16'd3, 1'b1,
                            {svtt_pkg::TAP_EX1DR, 1'b0, 1'b1, 1'b0}));
    // bogus DR move
    plan.push_back(step_row(svtt_pkg::BOGUS_DR_TMS, 4'd4, 1'b1, 1'b1,
                            svtt_pkg::BOGUS_DR_LEN, 1'b1,
                            {svtt_pkg::TAP_EX1DR, 1'b1, 1'b1, 1'b0}));
    // same byte, wrong length: walked
    plan.push_back(step_row(svtt_pkg::BOGUS_DR_TMS, 4'd4, 1'b1, 1'b1, 16'd5, 1'b0, '0));
    // into Capture-DR, then the next command clears the flag
    plan.push_back(step_row(8'h03, 4'd3, 1'b1, 1'b1, 16'd3, 1'b0, '0));
    plan.push_back(step_row(8'h00, 4'd1, 1'b1, 1'b1, 16'd1, 1'b0, '0));
    // one past the bit limit: dropped, across two beats
    plan.push_back(step_row(8'hFF, 4'd8, 1'b1, 1'b0, 16'(svtt_pkg::MAX_VECTOR_BITS + 1), 1'b1,
                            {svtt_pkg::TAP_SHDR, 1'b1, 1'b0, 1'b0}));
    plan.push_back(step_row(8'hFF, 4'd8, 1'b0, 1'b1, 16'd0, 1'b1,
                            {svtt_pkg::TAP_SHDR, 1'b1, 1'b0, 1'b0}));
    // exactly at the limit: tracked
    plan.push_back(step_row(8'hFF, 4'd8, 1'b1, 1'b0, 16'(svtt_pkg::MAX_VECTOR_BITS),
                            1'b0, '0));
    // largest length: dropped
    plan.push_back(step_row(8'h00, 4'd0, 1'b1, 1'b1, 16'hFFFF, 1'b1,
                            {svtt_pkg::TAP_TLR, 1'b1, 1'b0, 1'b0}));
    // zero length, count 15 clamps to 8 zeros
    plan.push_back(step_row(8'h00, 4'd15, 1'b1, 1'b1, 16'd0, 1'b1,
                            {svtt_pkg::TAP_RTI, 1'b0, 1'b1, 1'b1}));
    plan.push_back(step_row(8'hFF, 4'd0, 1'b1, 1'b1, 16'd1, 1'b0, '0));
    plan.push_back(step_row(8'hAA, 4'd9, 1'b1, 1'b0, 16'd9, 1'b0, '0));
    plan.push_back(step_row(8'h55, 4'd8, 1'b0, 1'b0, 16'd0, 1'b0, '0));
    plan.push_back(step_row(8'h00, 4'd12, 1'b0, 1'b1, 16'hFFFF, 1'b0, '0));
    // reset, walk to Capture-IR, then the flag clears
    plan.push_back(step_row(8'h1F, 4'd5, 1'b1, 1'b1, 16'd5, 1'b0, '0));
    plan.push_back(step_row(8'h06, 4'd4, 1'b1, 1'b1, 16'd4, 1'b0, '0));
    plan.push_back(step_row(8'h00, 4'd1, 1'b1, 1'b1, 16'd1, 1'b0, '0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i])
      send_beat(plan[i].beat, plan[i].fixed, plan[i].want);
    drain_results();

    while (beats_sent < plan.size() + RANDOM_BEATS) begin
      random_command();
      if (beats_sent >= plan.size() + RANDOM_BEATS / 2 &&
          beats_sent < plan.size() + RANDOM_BEATS / 2 + 4)
        drain_results();
    end
    cmd_valid <= 1'b0;

    while (tracked_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Result side: random stall ahead of each beat (none in full-rate stretches), then check it in order.
  initial begin : result_side
    int unsigned    hold;
    svtt_pkg::res_t want;
    while (rst) @(posedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 15);
      if (hold > 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!(res_valid && !res_stall));
      if (tracked_outcomes.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending: %p", res_beat));
      end else begin
        want = tracked_outcomes.pop_front();
        if (res_beat.tap_state !== want.tap_state)
          report_mismatch($sformatf("tap_state got %0d want %0d",
                                    res_beat.tap_state, want.tap_state));
        if (res_beat.move_skipped !== want.move_skipped)
          report_mismatch($sformatf("move_skipped got %b want %b",
                                    res_beat.move_skipped, want.move_skipped));
        if (res_beat.reset_seen !== want.reset_seen)
          report_mismatch($sformatf("reset_seen got %b want %b",
                                    res_beat.reset_seen, want.reset_seen));
        if (res_beat.session_done !== want.session_done)
          report_mismatch($sformatf("session_done got %b want %b",
                                    res_beat.session_done, want.session_done));
      end
    end
  end

endmodule

### shift_vector_tap_tracker.f
src/svtt_pkg.sv
src/svtt_walker.sv
src/shift_vector_tap_tracker.sv
sim/testbench.sv
